// File: src/sfr_pkg.sv
package sfr_pkg;

  localparam int unsigned CHAR_W          = 16;
  localparam int unsigned CNT_W           = 4;
  localparam int unsigned CFG_W           = 64;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned PATTERN_MAX_DEF = 8;
  localparam int unsigned REPLACE_MAX_DEF = 8;
  localparam int unsigned QUEUE_DEPTH     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO,
    REG_PAT_HI,
    REG_REP_LO,
    REG_REP_HI,
    REG_PAT_LEN,
    REG_REP_LEN,
    REG_MATCH_CASE
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LEAD_NONE,
    LEAD_CHAR,
    LEAD_REPL
  } lead_e;

  typedef struct packed {
    logic [CFG_W-1:0] pat_lo;
    logic [CFG_W-1:0] pat_hi;
    logic [CFG_W-1:0] rep_lo;
    logic [CFG_W-1:0] rep_hi;
    logic [CNT_W-1:0] pat_len;
    logic [CNT_W-1:0] rep_len;
    logic             match_case;
  } cfg_t;

  typedef struct packed {
    lead_e             lead;
    logic [CNT_W-1:0]  lead_n;
    logic [CHAR_W-1:0] lead_char;
    logic [CNT_W-1:0]  flush_n;
    logic              last;
    logic              replaced;
  } cmd_t;

  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c,
                                             input logic match_case);
    logic [CHAR_W-1:0] r;
    r = c;
    if (!match_case && c >= CHAR_W'(16'h0041) && c <= CHAR_W'(16'h005A)) begin
      r = c + CHAR_W'(16'h0020);
    end
    return r;
  endfunction

endpackage

// File: src/sfr_front.sv
module sfr_front #(
  parameter int unsigned PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int unsigned REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  sfr_pkg::cfg_t                                cfg_i,
  input  logic                                         win_clr_i,
  input  logic                                         in_valid_i,
  input  logic [sfr_pkg::CHAR_W-1:0]                   in_char_i,
  input  logic                                         in_last_i,
  output logic                                         in_ready_o,
  input  logic                                         full_i,
  output logic                                         push_o,
  output sfr_pkg::cmd_t                                cmd_o,
  output logic [PATTERN_MAX-1:0][sfr_pkg::CHAR_W-1:0]  snap_o
);

  localparam int unsigned CW = sfr_pkg::CNT_W;
  localparam int unsigned HW = sfr_pkg::CHAR_W;

  logic [PATTERN_MAX-1:0][HW-1:0] win_q, win_d, win_new;
  logic [CW-1:0] cnt_q, cnt_d, plen, rlen, c0, cnt1, cnt2;
  logic rep_q, rep_d, fire, full_win, match, taken;
  logic [2*sfr_pkg::CFG_W-1:0] pat;

  always_comb begin
    plen = (cfg_i.pat_len > CW'(PATTERN_MAX)) ? CW'(PATTERN_MAX) : cfg_i.pat_len;
    rlen = (cfg_i.rep_len > CW'(REPLACE_MAX)) ? CW'(REPLACE_MAX) : cfg_i.rep_len;
    pat  = {cfg_i.pat_hi, cfg_i.pat_lo};
    fire = in_valid_i && !full_i;
    c0   = (cnt_q >= plen) ? '0 : cnt_q;
    cnt1 = c0 + CW'(1);
    for (int j = 0; j < PATTERN_MAX; j++) begin
      win_new[j] = (CW'(j) == c0) ? in_char_i : win_q[j];
    end
    full_win = (cnt1 == plen);
    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (CW'(i) < plen && sfr_pkg::fold(win_new[i], cfg_i.match_case) !=
          sfr_pkg::fold(pat[i*HW +: HW], cfg_i.match_case)) begin
        match = 1'b0;
      end
    end
    taken = 1'b0;

    cmd_o.lead      = sfr_pkg::LEAD_NONE;
    cmd_o.lead_n    = '0;
    cmd_o.lead_char = '0;
    win_d           = win_new;
    cnt2            = cnt1;

    if (plen == '0) begin
      cmd_o.lead      = sfr_pkg::LEAD_CHAR;
      cmd_o.lead_n    = CW'(1);
      cmd_o.lead_char = in_char_i;
      win_d           = win_q;
      cnt2            = cnt_q;
    end else if (full_win && match) begin
      cmd_o.lead   = sfr_pkg::LEAD_REPL;
      cmd_o.lead_n = rlen;
      cnt2         = '0;
      taken        = 1'b1;
    end else if (full_win) begin
      cmd_o.lead      = sfr_pkg::LEAD_CHAR;
      cmd_o.lead_n    = CW'(1);
      cmd_o.lead_char = win_new[0];
      for (int j = 0; j < PATTERN_MAX - 1; j++) begin
        win_d[j] = win_new[j+1];
      end
      cnt2 = cnt1 - CW'(1);
    end

    cmd_o.flush_n  = in_last_i ? cnt2 : '0;
    cmd_o.last     = in_last_i;
    cmd_o.replaced = rep_q | taken;

    push_o     = fire && (cmd_o.lead_n != '0 || in_last_i);
    in_ready_o = !full_i;
    snap_o     = win_d;

    cnt_d = cnt_q;
    rep_d = rep_q;
    if (fire) begin
      cnt_d = in_last_i ? '0 : cnt2;
      rep_d = in_last_i ? 1'b0 : (rep_q | taken);
    end
    if (win_clr_i) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rep_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rep_q <= rep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      win_q <= win_d;
    end
  end

endmodule

// File: src/sfr_queue.sv
module sfr_queue #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = sfr_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] num_q, num_d;
  logic do_push, do_pop;

  always_comb begin
    full_o  = (num_q == NW'(DEPTH));
    valid_o = (num_q != '0);
    data_o  = mem_q[rd_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    wr_d    = wr_q;
    rd_d    = rd_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    num_d = num_q + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: src/sfr_back.sv
module sfr_back #(
  parameter int unsigned PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int unsigned REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  sfr_pkg::cfg_t                                cfg_i,
  input  logic                                         head_valid_i,
  input  sfr_pkg::cmd_t                                cmd_i,
  input  logic [PATTERN_MAX-1:0][sfr_pkg::CHAR_W-1:0]  snap_i,
  output logic                                         pop_o,
  output logic                                         out_valid_o,
  output logic [sfr_pkg::CHAR_W-1:0]                   out_char_o,
  output logic                                         out_char_valid_o,
  output logic                                         out_end_o,
  output logic                                         out_replaced_o,
  input  logic                                         out_ready_i
);

  localparam int unsigned CW = sfr_pkg::CNT_W;
  localparam int unsigned HW = sfr_pkg::CHAR_W;
  localparam int unsigned IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned RW = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

  logic [CW-1:0] idx_q, idx_d, total, fidx;
  logic [2*sfr_pkg::CFG_W-1:0] rep;
  logic load, final_beat, marker;
  logic [HW-1:0] beat_char;
  logic ovalid_q, ovalid_d, ocv_q, oend_q, orep_q;
  logic [HW-1:0] ochar_q;

  always_comb begin
    rep        = {cfg_i.rep_hi, cfg_i.rep_lo};
    total      = cmd_i.lead_n + cmd_i.flush_n;
    marker     = (total == '0);
    final_beat = marker || (idx_q == total - CW'(1));
    fidx       = idx_q - cmd_i.lead_n;
    load       = head_valid_i && (!ovalid_q || out_ready_i);
    pop_o      = load && final_beat;

    if (marker) begin
      beat_char = '0;
    end else if (idx_q < cmd_i.lead_n) begin
      if (cmd_i.lead == sfr_pkg::LEAD_REPL) begin
        beat_char = rep[idx_q[RW-1:0]*HW +: HW];
      end else begin
        beat_char = cmd_i.lead_char;
      end
    end else begin
      beat_char = snap_i[fidx[IW-1:0]];
    end

    idx_d = idx_q;
    if (load) begin
      idx_d = final_beat ? '0 : idx_q + CW'(1);
    end

    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end

    out_valid_o      = ovalid_q;
    out_char_o       = ochar_q;
    out_char_valid_o = ocv_q;
    out_end_o        = oend_q;
    out_replaced_o   = orep_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ochar_q <= beat_char;
      ocv_q   <= !marker;
      oend_q  <= final_beat && cmd_i.last;
      orep_q  <= final_beat && cmd_i.last && cmd_i.replaced;
    end
  end

endmodule

// File: src/stream_find_and_replace.sv
// Streaming find and replace over 16-bit text characters.
// Slave stream: tdata carries one character, tlast marks the final character
// of a text and flushes the match window. Master stream: tdata carries one
// character; tuser[0] says whether tdata holds a character (0 on an empty
// end marker), tuser[1] reports on the final word whether any replacement
// was made; tlast marks the final word of the text.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user
// must do so only while the block is idle, which the block does not enforce.
// Writing the pattern length empties the match window. Throughput: one input
// word per cycle while the queue is not full. The front compares the window
// in the cycle a word is taken and posts a command to a four-entry queue; the
// back gives one output word per cycle while the receiver is ready, up to
// eight per command, and the front stalls only when the queue fills. Reset
// clears the window count, the replaced flag, the queue, the output valid
// flag and all configuration registers. A receiver stall holds the output
// register; the queue keeps filling until it is full.
module stream_find_and_replace #(
  parameter int unsigned PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int unsigned REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sfr_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [sfr_pkg::CHAR_W-1:0]      s_axis_tdata_i,   // [15:0] text_char
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [sfr_pkg::CHAR_W-1:0]      m_axis_tdata_o,   // [15:0] out_char
  output logic [1:0]                      m_axis_tuser_o,   // [0] char_valid, [1] replaced_any
  output logic                            m_axis_tlast_o
);

  localparam int unsigned HW = sfr_pkg::CHAR_W;
  localparam int unsigned CW = sfr_pkg::CNT_W;
  localparam int unsigned QW = $bits(sfr_pkg::cmd_t) + PATTERN_MAX * HW;

  sfr_pkg::cfg_t cfg_q, cfg_d;
  logic win_clr;
  logic push, full, pop, head_valid;
  sfr_pkg::cmd_t cmd_in, cmd_head;
  logic [PATTERN_MAX-1:0][HW-1:0] snap_in, snap_head;
  logic [QW-1:0] q_in, q_out;
  logic cv, rep_any;

  always_comb begin
    cfg_d   = cfg_q;
    win_clr = 1'b0;
    if (cfg_we_i) begin
      unique case (sfr_pkg::cfg_reg_e'(cfg_idx_i))
        sfr_pkg::REG_PAT_LO:     cfg_d.pat_lo = cfg_wdata_i;
        sfr_pkg::REG_PAT_HI:     cfg_d.pat_hi = cfg_wdata_i;
        sfr_pkg::REG_REP_LO:     cfg_d.rep_lo = cfg_wdata_i;
        sfr_pkg::REG_REP_HI:     cfg_d.rep_hi = cfg_wdata_i;
        sfr_pkg::REG_PAT_LEN: begin
          cfg_d.pat_len = cfg_wdata_i[CW-1:0];
          win_clr       = 1'b1;
        end
        sfr_pkg::REG_REP_LEN:    cfg_d.rep_len = cfg_wdata_i[CW-1:0];
        sfr_pkg::REG_MATCH_CASE: cfg_d.match_case = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sfr_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .win_clr_i  (win_clr),
    .in_valid_i (s_axis_tvalid_i),
    .in_char_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .snap_o     (snap_in)
  );

  assign q_in = {snap_in, cmd_in};

  sfr_queue #(
    .WIDTH (QW),
    .DEPTH (sfr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (q_out)
  );

  assign {snap_head, cmd_head} = q_out;

  sfr_back #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .head_valid_i     (head_valid),
    .cmd_i            (cmd_head),
    .snap_i           (snap_head),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid_o),
    .out_char_o       (m_axis_tdata_o),
    .out_char_valid_o (cv),
    .out_end_o        (m_axis_tlast_o),
    .out_replaced_o   (rep_any),
    .out_ready_i      (m_axis_tready_i)
  );

  assign m_axis_tuser_o = {rep_any, cv};

endmodule
